FILE: hdl/sqve_pkg.sv
// shared constants and types for the sprite quad vertex expander
package sqve_pkg;

   localparam int TEX_TABLE_DEPTH = 8;
   localparam int TEX_SLOT_BITS   = $clog2(TEX_TABLE_DEPTH);
   localparam int TEX_COUNT_BITS  = $clog2(TEX_TABLE_DEPTH + 1);
   localparam int MAX_SPRITES     = 1024;
   localparam int SLOT_BITS       = 10;
   localparam int COUNT_BITS      = 11;
   localparam int CORNER_BITS     = 2;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

   localparam logic       FUNC_ADD     = 1'b0;
   localparam logic       FUNC_REFRESH = 1'b1;
   localparam logic [3:0] TEX_SLOT_NONE = 4'hF;

   // one classified sprite, ready for vertex generation
   typedef struct packed {
      logic                  rejected;
      logic                  full;
      logic [SLOT_BITS-1:0]  slot;
      logic signed [31:0]    x0;
      logic signed [31:0]    x1;
      logic signed [31:0]    y0;
      logic signed [31:0]    y1;
      logic [31:0]           color;
      logic [15:0]           u0;
      logic [15:0]           u1;
      logic [15:0]           v0;
      logic [15:0]           v1;
      logic [3:0]            tex_slot;
   } job_type;

   function automatic logic [31:0] sat_add_s32(logic [31:0] a, logic [31:0] b);
      logic [32:0] sum;
      sum = {a[31], a} + {b[31], b};
      if (sum[32] != sum[31]) begin
         return sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return sum[31:0];
   endfunction

   function automatic logic [15:0] sat_add_u16(logic [15:0] a, logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

endpackage

FILE: hdl/sprite_quad_vertex_expander_unit.sv
// top level of the sprite quad vertex expander
//
// req_* carries one sprite per word: an add at the next free batch slot or a
// refresh of the slot in req_object_index. rsp_* returns four vertex words per
// sprite in corner order (0,0), (1,0), (1,1), (0,1), the last flagged by
// rsp_last_vertex; an add into a full batch returns one word with rsp_rejected.
// csr_we/csr_wdata load the batch capacity (0 acts as 1, values above 1024 as
// 1024); write it only while the block is idle.
// Each sprite passes through the queue and the job register before its first vertex is loaded into the output register.
// Throughput: one vertex word per cycle while rsp_ready is high, set by the
// single output register that the vertex generator fills one corner at a time.
// The front end classifies a sprite in the cycle it is taken and a two-word
// queue lets it keep taking sprites while the output side is stalled; req_ready
// drops only when that queue is full. Holding rsp_ready low simply freezes the
// output word. Reset empties the queue, clears the sprite count and texture
// table fill and sets the capacity to 1024; it needs no clearing pass.
module sprite_quad_vertex_expander_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [sqve_pkg::COUNT_BITS-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic [sqve_pkg::SLOT_BITS-1:0] req_object_index,
   input  logic signed [31:0]             req_x_pos,
   input  logic signed [31:0]             req_y_pos,
   input  logic signed [31:0]             req_x_size,
   input  logic signed [31:0]             req_y_size,
   input  logic [31:0]                    req_color_rgba,
   input  logic [15:0]                    req_tex_u0,
   input  logic [15:0]                    req_tex_v0,
   input  logic [15:0]                    req_tex_u_span,
   input  logic [15:0]                    req_tex_v_span,
   input  logic [31:0]                    req_texture_id,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [11:0]                    rsp_vertex_number,
   output logic signed [31:0]             rsp_pos_x,
   output logic signed [31:0]             rsp_pos_y,
   output logic [31:0]                    rsp_vertex_color,
   output logic [15:0]                    rsp_tex_u,
   output logic [15:0]                    rsp_tex_v,
   output logic signed [3:0]              rsp_tex_slot,
   output logic                           rsp_last_vertex,
   output logic                           rsp_batch_full,
   output logic                           rsp_rejected
);
   import sqve_pkg::*;

   logic    push, queue_full, pop, job_valid;
   job_type push_job, pop_job;

   sqve_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_object_index (req_object_index),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_x_size       (req_x_size),
      .req_y_size       (req_y_size),
      .req_color_rgba   (req_color_rgba),
      .req_tex_u0       (req_tex_u0),
      .req_tex_v0       (req_tex_v0),
      .req_tex_u_span   (req_tex_u_span),
      .req_tex_v_span   (req_tex_v_span),
      .req_texture_id   (req_texture_id),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   sqve_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (job_valid),
      .pop_job   (pop_job)
   );

   sqve_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (job_valid),
      .job_in            (pop_job),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_vertex_color  (rsp_vertex_color),
      .rsp_tex_u         (rsp_tex_u),
      .rsp_tex_v         (rsp_tex_v),
      .rsp_tex_slot      (rsp_tex_slot),
      .rsp_last_vertex   (rsp_last_vertex),
      .rsp_batch_full    (rsp_batch_full),
      .rsp_rejected      (rsp_rejected)
   );

endmodule

FILE: hdl/sqve_front.sv
// front end: batch accounting, texture slot table and corner sums
module sqve_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [sqve_pkg::COUNT_BITS-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic [sqve_pkg::SLOT_BITS-1:0] req_object_index,
   input  logic signed [31:0]             req_x_pos,
   input  logic signed [31:0]             req_y_pos,
   input  logic signed [31:0]             req_x_size,
   input  logic signed [31:0]             req_y_size,
   input  logic [31:0]                    req_color_rgba,
   input  logic [15:0]                    req_tex_u0,
   input  logic [15:0]                    req_tex_v0,
   input  logic [15:0]                    req_tex_u_span,
   input  logic [15:0]                    req_tex_v_span,
   input  logic [31:0]                    req_texture_id,
   input  logic                           queue_full,
   output logic                           push,
   output sqve_pkg::job_type              push_job
);
   import sqve_pkg::*;

   logic [31:0]               tex_table [TEX_TABLE_DEPTH];
   logic [TEX_COUNT_BITS-1:0] tex_count_ff, tex_count_in;
   logic [COUNT_BITS-1:0]     sprite_count_ff, sprite_count_in;
   logic [COUNT_BITS-1:0]     capacity_ff, capacity_in;
   logic [COUNT_BITS-1:0]     eff_cap;
   logic                      is_add, reject, hit, tex_write;
   logic [TEX_SLOT_BITS-1:0]  hit_slot;
   logic [3:0]                tex_slot;
   logic [SLOT_BITS-1:0]      slot;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign is_add    = (req_func == FUNC_ADD);

   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = COUNT_BITS'(1);
      end else if (capacity_ff > COUNT_BITS'(MAX_SPRITES)) begin
         eff_cap = COUNT_BITS'(MAX_SPRITES);
      end else begin
         eff_cap = capacity_ff;
      end
   end

   assign reject = is_add && (sprite_count_ff >= eff_cap);

   // lowest matching live entry wins
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = TEX_TABLE_DEPTH - 1; i >= 0; i--) begin
         if ((TEX_COUNT_BITS'(i) < tex_count_ff) && (tex_table[i] == req_texture_id)) begin
            hit      = 1'b1;
            hit_slot = TEX_SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      tex_write = 1'b0;
      if (hit) begin
         tex_slot = 4'(hit_slot);
      end else if (tex_count_ff < TEX_COUNT_BITS'(TEX_TABLE_DEPTH)) begin
         tex_slot  = 4'(tex_count_ff);
         tex_write = 1'b1;
      end else begin
         tex_slot = TEX_SLOT_NONE;
      end
   end

   assign slot = is_add ? sprite_count_ff[SLOT_BITS-1:0] : req_object_index;

   always_comb begin
      sprite_count_in = sprite_count_ff;
      tex_count_in    = tex_count_ff;
      capacity_in     = csr_we ? csr_wdata : capacity_ff;
      if (push && !reject) begin
         if (is_add) begin
            sprite_count_in = sprite_count_ff + COUNT_BITS'(1);
         end
         if (tex_write) begin
            tex_count_in = tex_count_ff + TEX_COUNT_BITS'(1);
         end
      end
   end

   always_comb begin
      push_job = '0;
      push_job.rejected = reject;
      push_job.full     = 1'b1;
      if (!reject) begin
         push_job.full     = (sprite_count_in >= eff_cap);
         push_job.slot     = slot;
         push_job.x0       = req_x_pos;
         push_job.x1       = sat_add_s32(req_x_pos, req_x_size);
         push_job.y0       = req_y_pos;
         push_job.y1       = sat_add_s32(req_y_pos, req_y_size);
         push_job.color    = req_color_rgba;
         push_job.u0       = req_tex_u0;
         push_job.u1       = sat_add_u16(req_tex_u0, req_tex_u_span);
         push_job.v0       = req_tex_v0;
         push_job.v1       = sat_add_u16(req_tex_v0, req_tex_v_span);
         push_job.tex_slot = tex_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_count_ff    <= '0;
         sprite_count_ff <= '0;
         capacity_ff     <= COUNT_BITS'(MAX_SPRITES);
      end else begin
         tex_count_ff    <= tex_count_in;
         sprite_count_ff <= sprite_count_in;
         capacity_ff     <= capacity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !reject && tex_write) begin
         tex_table[tex_count_ff[TEX_SLOT_BITS-1:0]] <= req_texture_id;
      end
   end

endmodule

FILE: hdl/sqve_queue.sv
// short job queue between the front end and the vertex generator
module sqve_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sqve_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output sqve_pkg::job_type pop_job
);
   import sqve_pkg::*;

   job_type                     mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]     count_ff, count_in;

   assign full      = (count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: hdl/sqve_back.sv
// back end: walks the four corners of a job into the output register
module sqve_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   input  sqve_pkg::job_type              job_in,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [11:0]                    rsp_vertex_number,
   output logic signed [31:0]             rsp_pos_x,
   output logic signed [31:0]             rsp_pos_y,
   output logic [31:0]                    rsp_vertex_color,
   output logic [15:0]                    rsp_tex_u,
   output logic [15:0]                    rsp_tex_v,
   output logic signed [3:0]              rsp_tex_slot,
   output logic                           rsp_last_vertex,
   output logic                           rsp_batch_full,
   output logic                           rsp_rejected
);
   import sqve_pkg::*;

   job_type                 job_ff, job_in_sel;
   logic                    busy_ff, busy_in;
   logic [CORNER_BITS-1:0]  corner_ff, corner_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    load, is_last, cx, cy;
   logic [11:0]             vnum_ff;
   logic signed [31:0]      pos_x_ff, pos_y_ff;
   logic [31:0]             color_ff;
   logic [15:0]             u_ff, v_ff;
   logic [3:0]              tslot_ff;
   logic                    last_ff, full_ff, rej_ff;

   assign load    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign is_last = job_ff.rejected || (corner_ff == '1);
   // next job enters as the current one hands over its last word
   assign pop     = job_valid && (!busy_ff || (load && is_last));

   // corners in order (0,0) (1,0) (1,1) (0,1)
   assign cx = corner_ff[0] ^ corner_ff[1];
   assign cy = corner_ff[1];

   assign job_in_sel = pop ? job_in : job_ff;

   always_comb begin
      busy_in      = busy_ff;
      corner_in    = corner_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         corner_in    = corner_ff + CORNER_BITS'(1);
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in   = 1'b1;
         corner_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in_sel;
      if (load) begin
         if (job_ff.rejected) begin
            vnum_ff  <= '0;
            pos_x_ff <= '0;
            pos_y_ff <= '0;
            color_ff <= '0;
            u_ff     <= '0;
            v_ff     <= '0;
            tslot_ff <= '0;
         end else begin
            vnum_ff  <= {job_ff.slot, corner_ff};
            pos_x_ff <= cx ? job_ff.x1 : job_ff.x0;
            pos_y_ff <= cy ? job_ff.y1 : job_ff.y0;
            color_ff <= job_ff.color;
            u_ff     <= cx ? job_ff.u1 : job_ff.u0;
            v_ff     <= cy ? job_ff.v1 : job_ff.v0;
            tslot_ff <= job_ff.tex_slot;
         end
         last_ff <= is_last;
         full_ff <= job_ff.full;
         rej_ff  <= job_ff.rejected;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_number = vnum_ff;
   assign rsp_pos_x         = pos_x_ff;
   assign rsp_pos_y         = pos_y_ff;
   assign rsp_vertex_color  = color_ff;
   assign rsp_tex_u         = u_ff;
   assign rsp_tex_v         = v_ff;
   assign rsp_tex_slot      = tslot_ff;
   assign rsp_last_vertex   = last_ff;
   assign rsp_batch_full    = full_ff;
   assign rsp_rejected      = rej_ff;

endmodule
